// ----- rtl/loop_chunk_scheduler_macros.svh -----
// Assertion shorthands used by the checker.
// Every property samples on the rising edge of clk and is off while rst_n is low.
`ifndef LOOP_CHUNK_SCHEDULER_MACROS_SVH
`define LOOP_CHUNK_SCHEDULER_MACROS_SVH

// Same-cycle implication
`define LCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lcs_pkg.sv -----
package lcs_pkg;

  localparam int NUM_WORKERS_DEF = 4;

  localparam int IDX_W      = 32;  // loop indices and chunk bounds
  localparam int STEP_W     = 16;
  localparam int ITER_W     = 16;
  localparam int MODE_W     = 2;
  localparam int ID_W       = 2;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // 2*(end - cursor) + step*workers always fits in 34 bits
  localparam int OPA_W      = 34;
  localparam int SLOT_W_DEF = STEP_W + $clog2(NUM_WORKERS_DEF) + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_ITERS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE  = 3'd4;

  // schedule modes
  localparam logic [MODE_W-1:0] MODE_STATIC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GUIDED  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  thread_id;
    logic [CNT_W-1:0] request_count;
  } lcs_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] chunk_start;
    logic [IDX_W-1:0] chunk_end;
    logic             finished;
  } lcs_out_t;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

endpackage

// ----- rtl/lcs_mdu.sv -----
module lcs_mdu #(
  parameter int AW = lcs_pkg::OPA_W,
  parameter int BW = lcs_pkg::SLOT_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcs_pkg::mdu_req_t  req,
  input  logic [AW-1:0]      opa,
  input  logic [BW-1:0]      opb,
  output logic               done,
  output logic [AW+BW-1:0]   prod,
  output logic [AW-1:0]      quot
);
  import lcs_pkg::*;

  localparam int CW = $clog2(AW);

  logic          busy_r;
  logic          done_r;
  mdu_op_t       op_r;
  logic [AW-1:0] a_r;
  logic [BW-1:0] b_r;
  logic [AW:0]   acc_r;
  logic [AW:0]   acc_nxt;
  logic [AW-1:0] sh_r;
  logic [AW-1:0] sh_nxt;
  logic [CW-1:0] cnt_r;
  logic [AW:0]   trial;
  logic [AW:0]   opx;
  logic [AW:0]   opy;
  logic          sub;
  logic [AW+1:0] sum;
  logic [2*AW:0] cat;

  // one adder: shift-add for multiply, trial subtract for restoring divide
  always_comb begin
    trial = {acc_r[AW-1:0], sh_r[AW-1]};
    sub   = (op_r == MDU_DIV);
    opx   = sub ? trial : acc_r;
    opy   = sub ? (AW+1)'(b_r) : (sh_r[0] ? {1'b0, a_r} : '0);
    sum   = {1'b0, opx} + ({1'b0, opy} ^ {(AW+2){sub}}) + (AW+2)'(sub);
    if (sub) begin
      acc_nxt = sum[AW+1] ? trial : sum[AW:0];
      sh_nxt  = {sh_r[AW-2:0], ~sum[AW+1]};
    end else begin
      acc_nxt = {1'b0, sum[AW:1]};
      sh_nxt  = {sum[0], sh_r[AW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
      sh_r  <= (req.op == MDU_MUL) ? AW'(opb) : opa;
      cnt_r <= (req.op == MDU_MUL) ? CW'(BW-1) : CW'(AW-1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign cat  = {acc_r, sh_r};
  assign prod = cat[AW-BW +: AW+BW];
  assign quot = sh_r;
  assign done = done_r;

endmodule

// ----- rtl/loop_chunk_scheduler.sv -----
// Static requests run two multiplies (span, offset), dynamic one (step * size), guided a divide
//   and a multiply, all on the shared unit, BW = 17 + clog2(NUM_WORKERS) (19 at four workers);
//   an exhausted loop or unused mode goes straight to the output state.
// One request in flight; the next is taken once the block is back in idle after the result is
// loaded, so throughput is set by the shared bit-serial multiply/divide unit.
// Synchronous active-low reset: registers to their reset values, cursor 0.
module loop_chunk_scheduler #(
  parameter int NUM_WORKERS = lcs_pkg::NUM_WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lcs_pkg::lcs_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lcs_pkg::lcs_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lcs_pkg::*;

  // operand widths of the shared unit
  localparam int AW = OPA_W;                          // multiplicand / dividend
  localparam int DW = STEP_W + $clog2(NUM_WORKERS);   // step * workers
  localparam int BW = DW + 1;                         // multiplier / divisor / slot
  localparam int PW = AW + BW;                        // product
  localparam int XW = PW + 1;                         // unclamped bound

  typedef enum logic [3:0] {
    S_IDLE,
    S_CS_GO,      // chunk span = iterations * step
    S_CS_WAIT,
    S_SLOT_GO,    // offset = slot * span
    S_SLOT_WAIT,
    S_SBOUND,     // clamp static start, form raw end
    S_REM,        // guided: remaining = end - cursor
    S_NUM,        // numerator 2*remaining + d
    S_DIV_GO,     // divide by 2*d
    S_DIV_WAIT,
    S_SIZE,       // max(chunk_iterations, quotient)
    S_GROW_GO,    // step * size
    S_GROW_WAIT,
    S_END,        // clamp end, advance cursor in the shared modes
    S_OUT
  } state_t;

  state_t             state_r;

  // configuration
  logic [IDX_W-1:0]   loop_start_r;
  logic [STEP_W-1:0]  loop_step_r;
  logic [IDX_W-1:0]   loop_end_r;
  logic [ITER_W-1:0]  chunk_iter_r;
  logic [MODE_W-1:0]  mode_r;
  logic [IDX_W-1:0]   cursor_r;

  // working registers
  logic [BW-1:0]      slot_r;
  logic [IDX_W-1:0]   cs_r;
  logic [AW-1:0]      num_r;
  logic [AW-1:0]      size_r;
  logic [XW-1:0]      big_r;
  logic [IDX_W-1:0]   start_r;
  logic [IDX_W-1:0]   end_r;

  logic               out_valid_r;
  lcs_out_t           out_data_r;

  // combinational helpers
  logic [STEP_W-1:0]  step_eff;
  logic [DW-1:0]      d_w;
  logic [BW-1:0]      slot_w;
  logic [IDX_W-1:0]   bound;

  // shared unit
  mdu_req_t           mdu_req;
  logic [AW-1:0]      mdu_a;
  logic [BW-1:0]      mdu_b;
  logic               mdu_done;
  logic [PW-1:0]      mdu_prod;
  logic [AW-1:0]      mdu_quot;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [XW-1:0]    v,
                                                 input logic [IDX_W-1:0] lim);
    clamp_idx = (v > XW'(lim)) ? lim : v[IDX_W-1:0];
  endfunction

  // zero step behaves as one everywhere
  assign step_eff = (loop_step_r == '0) ? STEP_W'(1) : loop_step_r;
  assign d_w      = DW'(DW'(step_eff) * DW'(NUM_WORKERS));
  // static slot; thread ids at or above the worker count are used as given
  assign slot_w   = BW'(BW'(in_data.request_count) * BW'(NUM_WORKERS))
                  + BW'(in_data.thread_id);
  assign bound    = clamp_idx(big_r, loop_end_r);

  // operand steering: the unit latches its operands on the start cycle
  always_comb begin
    mdu_req = '{start: 1'b0, op: MDU_MUL};
    mdu_a   = '0;
    mdu_b   = '0;
    unique case (state_r)
      S_CS_GO: begin
        mdu_req = '{start: 1'b1, op: MDU_MUL};
        mdu_a   = AW'(chunk_iter_r);
        mdu_b   = BW'(step_eff);
      end
      S_SLOT_GO: begin
        mdu_req = '{start: 1'b1, op: MDU_MUL};
        mdu_a   = AW'(cs_r);
        mdu_b   = slot_r;
      end
      S_DIV_GO: begin
        // round half up: (2*rem + d) / (2*d)
        mdu_req = '{start: 1'b1, op: MDU_DIV};
        mdu_a   = num_r;
        mdu_b   = {d_w, 1'b0};
      end
      S_GROW_GO: begin
        mdu_req = '{start: 1'b1, op: MDU_MUL};
        mdu_a   = size_r;
        mdu_b   = BW'(step_eff);
      end
      default: ;
    endcase
  end

  lcs_mdu #(
    .AW (AW),
    .BW (BW)
  ) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_a),
    .opb   (mdu_b),
    .done  (mdu_done),
    .prod  (mdu_prod),
    .quot  (mdu_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cursor_r     <= '0;
      loop_start_r <= '0;
      loop_step_r  <= STEP_W'(1);
      loop_end_r   <= '0;
      chunk_iter_r <= ITER_W'(1);
      mode_r       <= MODE_STATIC;
    end else begin
      // result taken downstream; S_OUT handles its own refill
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            slot_r  <= slot_w;
            start_r <= cursor_r;
            size_r  <= AW'(chunk_iter_r);
            unique case (mode_r) inside
              MODE_STATIC: begin
                state_r <= S_CS_GO;
              end
              MODE_DYNAMIC, MODE_GUIDED: begin
                if (cursor_r >= loop_end_r) begin
                  // loop exhausted: empty chunk, cursor parks at the end
                  start_r  <= loop_end_r;
                  end_r    <= loop_end_r;
                  cursor_r <= loop_end_r;
                  state_r  <= S_OUT;
                end else if (mode_r == MODE_GUIDED) begin
                  state_r <= S_REM;
                end else begin
                  state_r <= S_GROW_GO;
                end
              end
              default: begin
                // unused mode: empty chunk, nothing else moves
                start_r <= loop_end_r;
                end_r   <= loop_end_r;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_CS_GO: state_r <= S_CS_WAIT;
        S_CS_WAIT: begin
          if (mdu_done) begin
            cs_r    <= mdu_prod[IDX_W-1:0];
            state_r <= S_SLOT_GO;
          end
        end
        S_SLOT_GO: state_r <= S_SLOT_WAIT;
        S_SLOT_WAIT: begin
          if (mdu_done) begin
            big_r   <= XW'(loop_start_r) + XW'(mdu_prod);
            state_r <= S_SBOUND;
          end
        end
        S_SBOUND: begin
          // start saturates at the loop end, raw end is start + span
          start_r <= bound;
          big_r   <= big_r + XW'(cs_r);
          state_r <= S_END;
        end
        S_REM: begin
          num_r   <= AW'(loop_end_r - cursor_r);
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r   <= {num_r[AW-2:0], 1'b0} + AW'(d_w);
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (mdu_done) begin
            state_r <= S_SIZE;
          end
        end
        S_SIZE: begin
          if (mdu_quot > size_r) begin
            size_r <= mdu_quot;
          end
          state_r <= S_GROW_GO;
        end
        S_GROW_GO: state_r <= S_GROW_WAIT;
        S_GROW_WAIT: begin
          if (mdu_done) begin
            big_r   <= XW'(cursor_r) + XW'(mdu_prod);
            state_r <= S_END;
          end
        end
        S_END: begin
          end_r <= bound;
          if (mode_r != MODE_STATIC) begin
            cursor_r <= bound;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // output register frees the front end as soon as it is loaded
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_data_r.chunk_start <= start_r;
            out_data_r.chunk_end   <= end_r;
            out_data_r.finished    <= (start_r == end_r);
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // register writes arrive only while idle, and hold off new requests
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LOOP_START: begin
            loop_start_r <= cfg_data[IDX_W-1:0];
            cursor_r     <= cfg_data[IDX_W-1:0];
          end
          REG_LOOP_STEP:   loop_step_r  <= cfg_data[STEP_W-1:0];
          REG_LOOP_END:    loop_end_r   <= cfg_data[IDX_W-1:0];
          REG_CHUNK_ITERS: chunk_iter_r <= cfg_data[ITER_W-1:0];
          REG_SCHED_MODE:  mode_r       <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall  = !rst_n || (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/lcs_checker.sv -----
`include "loop_chunk_scheduler_macros.svh"

module lcs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input lcs_pkg::lcs_out_t out_data
);

  `LCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  `LCS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while busy")

  `LCS_ASSERT_NOW(a_finished_flag, out_valid, out_data.finished == (out_data.chunk_start == out_data.chunk_end), "finished flag wrong")

  `LCS_ASSERT_NOW(a_chunk_order, out_valid, out_data.chunk_start <= out_data.chunk_end, "chunk end before start")

endmodule

bind loop_chunk_scheduler lcs_checker u_lcs_checker (.*);

// ----- verif/loop_chunk_scheduler_tb.sv -----
module loop_chunk_scheduler_tb;
  import lcs_pkg::*;

  localparam int WORKERS       = NUM_WORKERS_DEF;
  localparam int RANDOM_ITEMS  = 800;
  localparam int TAIL_ITEMS    = 100;   // last requests run with no idling
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES  = 100;   // above the slowest (guided) latency
  localparam int CYCLE_LIMIT   = 500000;

  // mode 3 has no name in the package; spare indexes are ignored by the block
  localparam logic [MODE_W-1:0]    MODE_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

  typedef enum bit {ROW_WRITE, ROW_ASK} row_kind_t;

  // one line of the directed table: a register write or a chunk request,
  // the latter optionally with its answer typed in
  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    lcs_in_t                req;
    bit                     known;
    lcs_out_t               answer;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  lcs_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  lcs_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // scheduler registers and shared cursor as the testbench sees them
  logic [IDX_W-1:0]   sch_start;
  logic [STEP_W-1:0]  sch_step;
  logic [IDX_W-1:0]   sch_end;
  logic [ITER_W-1:0]  sch_iters;
  logic [MODE_W-1:0]  sch_mode;
  logic [IDX_W-1:0]   sch_cursor;

  lcs_out_t   due_chunks[$];    // chunks granted but not yet seen at the output
  lcs_out_t   seen_want;
  stim_row_t  directed[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  tx_idle_en     = 1'b1;
  bit  rx_idle_en     = 1'b1;
  bit  hold_req       = 1'b0;

  loop_chunk_scheduler #(.NUM_WORKERS(WORKERS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] clip_to_end(logic [63:0] v);
    return (v > 64'(sch_end)) ? 64'(sch_end) : v;
  endfunction

  function automatic logic [63:0] eff_step();
    return (sch_step == '0) ? 64'd1 : 64'(sch_step);
  endfunction

  // register write as the block applies it; narrow registers drop upper bits
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LOOP_START: begin
        sch_start  = val[IDX_W-1:0];
        sch_cursor = val[IDX_W-1:0];    // start write reloads the cursor
      end
      REG_LOOP_STEP:   sch_step  = val[STEP_W-1:0];
      REG_LOOP_END:    sch_end   = val[IDX_W-1:0];
      REG_CHUNK_ITERS: sch_iters = val[ITER_W-1:0];
      REG_SCHED_MODE:  sch_mode  = val[MODE_W-1:0];
      default: ;
    endcase
  endfunction

  // chunk granted for one request; advances the cursor in the shared modes
  function automatic lcs_out_t grant_chunk(lcs_in_t req);
    logic [63:0] stp, cs, slot, raw, lo, hi, cur, size, rem, d, q;
    lcs_out_t    res;
    stp = eff_step();
    lo  = 64'(sch_end);
    hi  = 64'(sch_end);
    case (sch_mode)
      MODE_STATIC: begin
        // exact 64-bit arithmetic, then both bounds saturate at the loop end
        cs   = 64'(sch_iters) * stp;
        slot = 64'(req.request_count) * 64'(WORKERS) + 64'(req.thread_id);
        raw  = 64'(sch_start) + slot * cs;
        lo   = clip_to_end(raw);
        hi   = clip_to_end(raw + cs);
      end
      MODE_DYNAMIC, MODE_GUIDED: begin
        cur = 64'(sch_cursor);
        if (cur < 64'(sch_end)) begin
          size = 64'(sch_iters);
          if (sch_mode == MODE_GUIDED) begin
            // remaining / (step * workers), halves rounded up
            rem = 64'(sch_end) - cur;
            d   = stp * 64'(WORKERS);
            q   = (2 * rem + d) / (2 * d);
            if (q > size) size = q;
          end
          lo = cur;
          hi = clip_to_end(cur + stp * size);
        end
        sch_cursor = hi[IDX_W-1:0];
      end
      default: ;    // unused mode: empty chunk at the loop end
    endcase
    res.chunk_start = lo[IDX_W-1:0];
    res.chunk_end   = hi[IDX_W-1:0];
    res.finished    = (lo == hi);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r.kind   = ROW_WRITE;
    r.idx    = idx;
    r.val    = val;
    r.req    = '0;
    r.known  = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  function automatic stim_row_t ask_row(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
    stim_row_t r;
    r.kind                  = ROW_ASK;
    r.idx                   = '0;
    r.val                   = '0;
    r.req.thread_id         = id;
    r.req.request_count     = cnt;
    r.known                 = 1'b0;
    r.answer                = '0;
    return r;
  endfunction

  function automatic stim_row_t ask_row_known(logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt,
                                              logic [IDX_W-1:0] s, logic [IDX_W-1:0] e,
                                              logic f);
    stim_row_t r;
    r                    = ask_row(id, cnt);
    r.known              = 1'b1;
    r.answer.chunk_start = s;
    r.answer.chunk_end   = e;
    r.answer.finished    = f;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every action begins at a falling edge, so a request that has
  // just been taken is either replaced or withdrawn in that one step.
  // ---------------------------------------------------------------------------

  task automatic push_request(lcs_in_t req, bit known, lcs_out_t answer);
    lcs_out_t pred;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pred = grant_chunk(req);     // state moves on even when the answer is typed
    due_chunks.push_back(known ? answer : pred);
  endtask

  // withdraw the input and wait for every granted chunk to come out;
  // each request yields exactly one result, so an empty store means idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_chunks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // new random schedule, all five registers written in a shuffled order
  task automatic random_setting();
    logic [CFG_DATA_W-1:0] val [5];
    int                    order [5];
    int                    r, j, tmp;
    logic [63:0]           cs, top;
    r = $urandom_range(0, 9);
    val[REG_SCHED_MODE] = (r == 0) ? 32'(MODE_UNUSED)  :
                          (r < 4)  ? 32'(MODE_STATIC)  :
                          (r < 7)  ? 32'(MODE_DYNAMIC) : 32'(MODE_GUIDED);
    r = $urandom_range(0, 9);
    val[REG_LOOP_STEP] = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF :
                         (r == 2) ? 32'($urandom_range(0, 65535)) : 32'($urandom_range(1, 8));
    r = $urandom_range(0, 9);
    val[REG_CHUNK_ITERS] = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF :
                           (r == 2) ? 32'($urandom_range(0, 65535)) :
                                      32'($urandom_range(1, 16));
    // occasional junk above the register width must be dropped
    if ($urandom_range(0, 7) == 0) val[REG_LOOP_STEP]   |= $urandom & 32'hFFFF_0000;
    if ($urandom_range(0, 7) == 0) val[REG_CHUNK_ITERS] |= $urandom & 32'hFFFF_0000;
    if ($urandom_range(0, 7) == 0) val[REG_SCHED_MODE]  |= $urandom & 32'hFFFF_FFFC;

    r = $urandom_range(0, 9);
    val[REG_LOOP_START] = (r == 0) ? 32'd0 :
                          (r == 1) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 4000)) : $urandom;

    // loop end mostly a few dozen chunks past the start, so the shared
    // modes walk through a whole loop; sometimes empty, reversed or maximal
    cs = ((val[REG_LOOP_STEP][15:0] == 0) ? 64'd1 : 64'(val[REG_LOOP_STEP][15:0])) *
         64'(val[REG_CHUNK_ITERS][15:0]);
    if (cs == 0) cs = 1;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      val[REG_LOOP_END] = $urandom;
    end else if (r == 1) begin
      val[REG_LOOP_END] = 32'hFFFF_FFFF;
    end else if (r == 2) begin
      val[REG_LOOP_END] = val[REG_LOOP_START];
    end else begin
      top = 64'(val[REG_LOOP_START]) + cs * 64'($urandom_range(1, 40)) + 64'($urandom) % cs;
      val[REG_LOOP_END] = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0];
    end

    for (int i = 0; i < 5; i++) order[i] = i;
    for (int i = 4; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) write_reg(CFG_IDX_W'(order[i]), val[order[i]]);
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request,
  // counted here so the sender keeps offering requests meanwhile
  // ---------------------------------------------------------------------------

  initial begin : rx_side
    int burst;
    int hold_left;
    burst     = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst     = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare every delivered chunk with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_chunks.size() == 0) begin
        $display("%0t: chunk with none due: start %h end %h finished %b", $time,
                 out_data.chunk_start, out_data.chunk_end, out_data.finished);
        mismatch_count++;
      end else begin
        seen_want = due_chunks.pop_front();
        if (out_data.chunk_start !== seen_want.chunk_start) begin
          $display("%0t: chunk_start expected %h actual %h", $time,
                   seen_want.chunk_start, out_data.chunk_start);
          mismatch_count++;
        end
        if (out_data.chunk_end !== seen_want.chunk_end) begin
          $display("%0t: chunk_end expected %h actual %h", $time,
                   seen_want.chunk_end, out_data.chunk_end);
          mismatch_count++;
        end
        if (out_data.finished !== seen_want.finished) begin
          $display("%0t: finished expected %b actual %b", $time,
                   seen_want.finished, out_data.finished);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    lcs_in_t     req;
    int          random_sent;
    int          phase;
    int          n;
    logic [63:0] cs, lim;

    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    sch_start  = '0;
    sch_step   = 16'd1;
    sch_end    = '0;
    sch_iters  = 16'd1;
    sch_mode   = MODE_STATIC;
    sch_cursor = '0;

    // after reset: empty loop, every static chunk sits at the end
    directed.push_back(ask_row_known(2'd0, 16'd0, 32'd0, 32'd0, 1'b1));
    // static, ten-iteration chunks over 0..1000
    directed.push_back(reg_row(REG_LOOP_END, 32'd1000));
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'd10));
    directed.push_back(ask_row_known(2'd0, 16'd0, 32'd0, 32'd10, 1'b0));
    directed.push_back(ask_row_known(2'd3, 16'd0, 32'd30, 32'd40, 1'b0));
    directed.push_back(ask_row_known(2'd3, 16'hFFFF, 32'd1000, 32'd1000, 1'b1));
    directed.push_back(ask_row(2'd2, 16'd24));
    directed.push_back(ask_row(2'd3, 16'd24));
    // static overflow near the top of the index range saturates
    directed.push_back(reg_row(REG_LOOP_START, 32'hFFFF_FF00));
    directed.push_back(reg_row(REG_LOOP_END, 32'hFFFF_FFFF));
    directed.push_back(reg_row(REG_LOOP_STEP, 32'hFFFF));
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'hFFFF));
    directed.push_back(ask_row_known(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(ask_row(2'd0, 16'd0));
    // zero step acts as one; zero chunk size gives empty chunks
    directed.push_back(reg_row(REG_LOOP_STEP, 32'd0));
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'd0));
    directed.push_back(ask_row_known(2'd1, 16'd5, 32'hFFFF_FF00, 32'hFFFF_FF00, 1'b1));
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'd3));
    directed.push_back(ask_row(2'd1, 16'd2));
    // dynamic: cursor walks 50..100 in steps of 12, last chunk clipped
    directed.push_back(reg_row(REG_SCHED_MODE, 32'(MODE_DYNAMIC)));
    directed.push_back(reg_row(REG_LOOP_STEP, 32'd3));
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'd4));
    directed.push_back(reg_row(REG_LOOP_END, 32'd100));
    directed.push_back(reg_row(REG_LOOP_START, 32'd50));
    directed.push_back(ask_row_known(2'd0, 16'd0, 32'd50, 32'd62, 1'b0));
    directed.push_back(ask_row(2'd1, 16'd7));
    directed.push_back(ask_row(2'd2, 16'hFFFF));
    directed.push_back(ask_row(2'd3, 16'd0));
    directed.push_back(ask_row(2'd0, 16'd1));
    directed.push_back(ask_row_known(2'd1, 16'd1, 32'd100, 32'd100, 1'b1));
    // cursor loaded beyond the loop end
    directed.push_back(reg_row(REG_LOOP_START, 32'd200));
    directed.push_back(ask_row_known(2'd2, 16'd3, 32'd100, 32'd100, 1'b1));
    // guided: a quarter of what is left, halves rounded up
    directed.push_back(reg_row(REG_SCHED_MODE, 32'(MODE_GUIDED)));
    directed.push_back(reg_row(REG_LOOP_END, 32'd1000));
    directed.push_back(reg_row(REG_LOOP_STEP, 32'd1));
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'd2));
    directed.push_back(reg_row(REG_LOOP_START, 32'd0));
    directed.push_back(ask_row_known(2'd0, 16'd0, 32'd0, 32'd250, 1'b0));
    directed.push_back(ask_row(2'd1, 16'd0));
    directed.push_back(ask_row(2'd2, 16'd0));
    // guided with zero chunk size and zero step: quotient alone
    directed.push_back(reg_row(REG_CHUNK_ITERS, 32'd0));
    directed.push_back(reg_row(REG_LOOP_STEP, 32'd0));
    directed.push_back(ask_row(2'd3, 16'd0));
    directed.push_back(ask_row(2'd0, 16'd0));
    // unused mode, then writes to indexes that do not exist
    directed.push_back(reg_row(REG_SCHED_MODE, 32'(MODE_UNUSED)));
    directed.push_back(ask_row_known(2'd1, 16'd9, 32'd1000, 32'd1000, 1'b1));
    directed.push_back(reg_row(REG_SPARE_LO, 32'd1));
    directed.push_back(reg_row(REG_SPARE_HI, 32'd0));
    directed.push_back(ask_row_known(2'd2, 16'd9, 32'd1000, 32'd1000, 1'b1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        push_request(directed[i].req, directed[i].known, directed[i].answer);
      end
    end

    // random phases: fresh schedule, then a run of requests against it
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      random_setting();
      if (random_sent >= RANDOM_ITEMS - TAIL_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (phase == 3) hold_req = 1'b1;   // block fills and stalls its input

      n = $urandom_range(10, 50);
      repeat (n) begin
        req.thread_id = ID_W'($urandom_range(0, WORKERS - 1));
        if (sch_mode == MODE_STATIC && $urandom_range(0, 7) != 0) begin
          // counts that mostly land inside the loop, a few past it
          cs = eff_step() * 64'(sch_iters);
          if (cs == 0 || sch_end <= sch_start)
            lim = 8;
          else
            lim = (64'(sch_end) - 64'(sch_start)) / cs / 64'(WORKERS) + 2;
          if (lim > 65535) lim = 65535;
          req.request_count = CNT_W'($urandom_range(0, int'(lim)));
        end else begin
          req.request_count = CNT_W'($urandom_range(0, 65535));
        end
        push_request(req, 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
